>>> src/mcbp_pkg.sv
// shared types and constants for the msb-first code bit packer
`timescale 1ns / 1ps

package mcbp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CODE_W      = 32;
    localparam int unsigned CODE_LEN_W  = 6;
    localparam int unsigned BIT_CNT_W   = 3;

    // item mode codes
    localparam logic MODE_PUT    = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [CODE_W-1:0]     code_value;
        logic [CODE_LEN_W-1:0] code_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_bytes;
        logic last_byte;
    } t_status;

endpackage

>>> src/mcbp_ctrl.sv
// controller state machine for the msb-first code bit packer
`timescale 1ns / 1ps

module mcbp_ctrl
    import mcbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall,
    output logic    o_valid
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.shift = 1'b0;
        o_stall     = 1'b1;
        o_valid     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.has_bytes) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/mcbp_dp.sv
// bit accumulator and byte emitter datapath for the msb-first code bit packer
`timescale 1ns / 1ps

module mcbp_dp
    import mcbp_pkg::*;
#(
    parameter int unsigned MAX_CODE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_item
);

    localparam int unsigned ACC_W     = MAX_CODE_BITS + BYTE_W;
    localparam int unsigned LEN_W     = $clog2(MAX_CODE_BITS + 1);
    localparam int unsigned TOT_W     = $clog2(MAX_CODE_BITS + BYTE_W);
    localparam int unsigned SHIFT_W   = $clog2(ACC_W + 1);
    localparam int unsigned MAX_BYTES = (MAX_CODE_BITS + BYTE_W - 1) / BYTE_W;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      n_acc;
    logic [BIT_CNT_W-1:0]  r_bit_count;
    logic [BIT_CNT_W-1:0]  n_bit_count;
    logic [CNT_W-1:0]      r_byte_cnt;
    logic [CNT_W-1:0]      n_byte_cnt;

    logic [LEN_W-1:0]        len_sat;
    logic [TOT_W-1:0]        total;
    logic [CNT_W-1:0]        new_bytes;
    logic [SHIFT_W-1:0]      shamt;
    logic [ACC_W+CODE_W-1:0] code_wide;
    logic [ACC_W-1:0]        code_ext;
    logic [ACC_W-1:0]        code_mask;
    logic [ACC_W-1:0]        acc_put;
    logic [ACC_W-1:0]        acc_fin;

    // saturate length and place the new code bits right after the pending ones
    always_comb begin
        if (i_item.code_length > CODE_LEN_W'(MAX_CODE_BITS)) begin
            len_sat = LEN_W'(MAX_CODE_BITS);
        end else begin
            len_sat = LEN_W'(i_item.code_length);
        end
        total     = TOT_W'(r_bit_count) + TOT_W'(len_sat);
        code_wide = {{ACC_W{1'b0}}, i_item.code_value};
        code_mask = ~({ACC_W{1'b1}} << len_sat);
        code_ext  = code_wide[ACC_W-1:0] & code_mask;
        shamt     = SHIFT_W'(ACC_W) - SHIFT_W'(r_bit_count) - SHIFT_W'(len_sat);
        acc_put   = {r_acc[ACC_W-1 -: BYTE_W], {MAX_CODE_BITS{1'b0}}}
                    | (code_ext << shamt);
        acc_fin   = {r_acc[ACC_W-1 -: BYTE_W], {MAX_CODE_BITS{1'b0}}};
    end

    // bytes completed by the incoming item
    always_comb begin
        if (i_item.mode == MODE_FINISH) begin
            new_bytes = (r_bit_count != '0) ? CNT_W'(1) : '0;
        end else begin
            new_bytes = CNT_W'(total >> BIT_CNT_W);
        end
    end

    // accumulator update: load an item or drop the byte just taken
    always_comb begin
        n_acc       = r_acc;
        n_bit_count = r_bit_count;
        n_byte_cnt  = r_byte_cnt;
        if (i_cmd.load) begin
            if (i_item.mode == MODE_FINISH) begin
                n_acc       = acc_fin;
                n_bit_count = '0;
            end else begin
                n_acc       = acc_put;
                n_bit_count = total[BIT_CNT_W-1:0];
            end
            n_byte_cnt = new_bytes;
        end else if (i_cmd.shift) begin
            n_acc      = r_acc << BYTE_W;
            n_byte_cnt = r_byte_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_bit_count <= '0;
            r_byte_cnt  <= '0;
        end else begin
            r_acc       <= n_acc;
            r_bit_count <= n_bit_count;
            r_byte_cnt  <= n_byte_cnt;
        end
    end

    // status and output item
    assign o_status.has_bytes = (new_bytes != '0);
    assign o_status.last_byte = (r_byte_cnt == CNT_W'(1));
    assign o_item.out_byte    = r_acc[ACC_W-1 -: BYTE_W];
    assign o_item.last_of_run = (r_byte_cnt == CNT_W'(1));

endmodule

>>> src/msb_first_code_bit_packer.sv
// top level of the msb-first variable-length code bit packer
`timescale 1ns / 1ps

// Packs codewords of 0 to MAX_CODE_BITS bits into bytes, first bit in bit 7.
// A put item appends the low code_length bits of code_value (lengths above
// MAX_CODE_BITS saturate); a finish item flushes a pending partial byte padded
// with zeros. Once an item is taken, each completed byte it makes
// is offered for one cycle (longer under stall) through the single byte output,
// with last_of_run on the final one. The block takes no new item until all
// bytes of the current one are delivered; an item yields n completed bytes,
// with n from 0 to 4 at the default width.

module msb_first_code_bit_packer
    import mcbp_pkg::*;
#(
    parameter int unsigned MAX_CODE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_cmd    cmd;
    t_status status;

    // controller
    mcbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    // datapath
    mcbp_dp #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_item)
    );

`ifndef SYNTHESIS
    // no item is taken while a byte is being offered
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("item accepted while output pending");

    // the byte marked last ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_item.last_of_run) |=> !o_valid)
        else $error("output continued after last byte");

    // a finish yields at most one byte, marked last
    a_finish_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_item.mode == MODE_FINISH)
        |=> (!o_valid || o_item.last_of_run))
        else $error("finish produced more than one byte");
`endif

endmodule
